// ===== design/adc_sra_pkg.sv =====
// shared types, codes and register width table for the adc spi register sequencer
`timescale 1ns / 1ps
`default_nettype none

package adc_sra_pkg;

    // parameter defaults
    localparam int REGISTER_COUNT_DEF = 57;
    localparam int FRAME_BYTES_DEF    = 8;

    // event codes on the mode field
    localparam logic [1:0] MODE_NEW_JOB = 2'd0;
    localparam logic [1:0] MODE_XFER    = 2'd1;
    localparam logic [1:0] MODE_RDY_LOW = 2'd2;

    // job kinds
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // sequencer phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BUSY = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;

    // frame constants
    localparam int         RESET_BYTES = 8;
    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [7:0] CMD_READ    = 8'h40;
    localparam logic [7:0] CMD_WRITE   = 8'h00;
    localparam logic [5:0] DATA_REG    = 6'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  operation;
        logic [5:0]  reg_addr;
        logic [23:0] write_data;
        logic        append_status;
        logic        rdy_level;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        chip_select;
        logic        done_res;
        logic [31:0] read_value;
        logic        rejected;
    } result_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] bytes_left;
        logic [3:0] bytes_received;
        logic [1:0] cur_op;
    } ctrl_t;

    // register width in bytes by address, before the register count limit
    function automatic logic [1:0] reg_width_lut(input logic [5:0] addr);
        logic [1:0] w;
        case (addr)
            6'd0:    w = 2'd1;
            6'd1:    w = 2'd2;
            6'd2:    w = 2'd3;
            6'd3:    w = 2'd3;
            6'd4:    w = 2'd2;
            6'd5:    w = 2'd1;
            6'd6:    w = 2'd3;
            6'd7:    w = 2'd3;
            6'd8:    w = 2'd1;
            default:
            begin
                if (addr <= 6'd32)
                    w = 2'd2;
                else if (addr <= 6'd56)
                    w = 2'd3;
                else
                    w = 2'd0;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/adc_sra_step.sv =====
// next-state and result logic for one event of the register sequencer
`timescale 1ns / 1ps
`default_nettype none

module adc_sra_step #(
    parameter int REGISTER_COUNT = adc_sra_pkg::REGISTER_COUNT_DEF,
    parameter int FRAME_BYTES    = adc_sra_pkg::FRAME_BYTES_DEF
) (
    input  adc_sra_pkg::item_t   item,
    input  adc_sra_pkg::ctrl_t   ctrl,
    input  logic [7:0]           frame_cur [FRAME_BYTES],
    output adc_sra_pkg::ctrl_t   ctrl_next,
    output logic [7:0]           frame_next [FRAME_BYTES],
    output adc_sra_pkg::result_t res
);

    localparam int         IDX_W  = $clog2(FRAME_BYTES);
    localparam logic [4:0] FB_LIM = 5'(FRAME_BYTES);

    logic [1:0]  len;
    logic [3:0]  rx_count;
    logic [7:0]  cmd_byte;
    logic [7:0]  tx_pick;
    logic [31:0] assembled;
    logic        data_reg_hit;
    logic [7:0]  frame_rx [FRAME_BYTES];

    // register width, zero beyond the register count
    always_comb
    begin
        if ({1'b0, item.reg_addr} < 7'(REGISTER_COUNT))
            len = adc_sra_pkg::reg_width_lut(item.reg_addr);
        else
            len = 2'd0;
    end

    assign data_reg_hit = (item.reg_addr == adc_sra_pkg::DATA_REG);
    assign rx_count     = ctrl.bytes_received + 4'd1;

    // buffer with the received byte stored, overrun bytes are dropped
    always_comb
    begin
        frame_rx = frame_cur;
        if ({1'b0, ctrl.bytes_received} < FB_LIM)
            frame_rx[ctrl.bytes_received[IDX_W-1:0]] = item.rx_byte;
    end

    // byte to send after an exchange, out-of-range slots read as zero
    always_comb
    begin
        if (ctrl.cur_op == adc_sra_pkg::OP_RESET)
            tx_pick = adc_sra_pkg::FILL_BYTE;
        else if ({1'b0, rx_count} < FB_LIM)
            tx_pick = frame_rx[rx_count[IDX_W-1:0]];
        else
            tx_pick = 8'h00;
    end

    // big-endian read result, status byte on top
    always_comb
    begin
        case (rx_count)
            4'd5:    assembled = {frame_rx[IDX_W'(4)], frame_rx[IDX_W'(1)],
                                  frame_rx[IDX_W'(2)], frame_rx[IDX_W'(3)]};
            4'd4:    assembled = {8'h00, frame_rx[IDX_W'(1)],
                                  frame_rx[IDX_W'(2)], frame_rx[IDX_W'(3)]};
            4'd3:    assembled = {16'h0000, frame_rx[IDX_W'(1)], frame_rx[IDX_W'(2)]};
            4'd2:    assembled = {24'h000000, frame_rx[IDX_W'(1)]};
            default: assembled = 32'h0;
        endcase
    end

    // event decode
    always_comb
    begin
        ctrl_next       = ctrl;
        frame_next      = frame_cur;
        res             = '0;
        res.chip_select = (ctrl.phase != adc_sra_pkg::PH_IDLE);
        cmd_byte        = 8'h00;

        case (item.mode)
            adc_sra_pkg::MODE_NEW_JOB:
            begin
                if (ctrl.phase != adc_sra_pkg::PH_IDLE)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    case (item.operation)
                        adc_sra_pkg::OP_RESET:
                        begin
                            for (int i = 0; i < FRAME_BYTES; i++)
                            begin
                                if (i < adc_sra_pkg::RESET_BYTES)
                                    frame_next[IDX_W'(i)] = adc_sra_pkg::FILL_BYTE;
                            end
                            ctrl_next.cur_op         = adc_sra_pkg::OP_RESET;
                            ctrl_next.phase          = adc_sra_pkg::PH_BUSY;
                            ctrl_next.bytes_left     = 4'(adc_sra_pkg::RESET_BYTES - 1);
                            ctrl_next.bytes_received = 4'd0;
                            res.send_valid           = 1'b1;
                            res.send_byte            = adc_sra_pkg::FILL_BYTE;
                            res.chip_select          = 1'b1;
                        end
                        adc_sra_pkg::OP_READ:
                        begin
                            cmd_byte = adc_sra_pkg::CMD_READ | {2'b00, item.reg_addr};
                            for (int i = 1; i < FRAME_BYTES; i++)
                                frame_next[IDX_W'(i)] = 8'h00;
                            frame_next[0]    = cmd_byte;
                            ctrl_next.cur_op = adc_sra_pkg::OP_READ;
                            ctrl_next.bytes_left = {2'b00, len} + 4'd1
                                + {3'b000, data_reg_hit & item.append_status};
                            res.chip_select  = 1'b1;
                            if (data_reg_hit && item.rdy_level)
                            begin
                                ctrl_next.phase = adc_sra_pkg::PH_WAIT;
                            end
                            else
                            begin
                                ctrl_next.phase          = adc_sra_pkg::PH_BUSY;
                                ctrl_next.bytes_left     = ctrl_next.bytes_left - 4'd1;
                                ctrl_next.bytes_received = 4'd0;
                                res.send_valid           = 1'b1;
                                res.send_byte            = cmd_byte;
                            end
                        end
                        adc_sra_pkg::OP_WRITE:
                        begin
                            cmd_byte      = adc_sra_pkg::CMD_WRITE | {2'b00, item.reg_addr};
                            frame_next[0] = cmd_byte;
                            // data bytes, most significant first
                            case (len)
                                2'd1:
                                begin
                                    frame_next[1] = item.write_data[7:0];
                                end
                                2'd2:
                                begin
                                    frame_next[1] = item.write_data[15:8];
                                    frame_next[2] = item.write_data[7:0];
                                end
                                2'd3:
                                begin
                                    frame_next[1] = item.write_data[23:16];
                                    frame_next[2] = item.write_data[15:8];
                                    frame_next[3] = item.write_data[7:0];
                                end
                                default:
                                begin
                                end
                            endcase
                            ctrl_next.cur_op         = adc_sra_pkg::OP_WRITE;
                            ctrl_next.phase          = adc_sra_pkg::PH_BUSY;
                            ctrl_next.bytes_left     = {2'b00, len};
                            ctrl_next.bytes_received = 4'd0;
                            res.send_valid           = 1'b1;
                            res.send_byte            = cmd_byte;
                            res.chip_select          = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            adc_sra_pkg::MODE_XFER:
            begin
                if (ctrl.phase == adc_sra_pkg::PH_BUSY)
                begin
                    // store the received byte
                    frame_next               = frame_rx;
                    ctrl_next.bytes_received = rx_count;
                    if (ctrl.bytes_left != 4'd0)
                    begin
                        ctrl_next.bytes_left = ctrl.bytes_left - 4'd1;
                        res.send_valid       = 1'b1;
                        res.send_byte        = tx_pick;
                    end
                    else
                    begin
                        ctrl_next.phase = adc_sra_pkg::PH_IDLE;
                        res.chip_select = 1'b0;
                        res.done_res    = 1'b1;
                        if (ctrl.cur_op == adc_sra_pkg::OP_READ)
                            res.read_value = assembled;
                    end
                end
            end
            adc_sra_pkg::MODE_RDY_LOW:
            begin
                if (ctrl.phase == adc_sra_pkg::PH_WAIT)
                begin
                    ctrl_next.phase          = adc_sra_pkg::PH_BUSY;
                    ctrl_next.bytes_left     = ctrl.bytes_left - 4'd1;
                    ctrl_next.bytes_received = 4'd0;
                    res.send_valid           = 1'b1;
                    res.send_byte            = frame_cur[0];
                    res.chip_select          = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/adc_spi_register_access_sequencer_core.sv =====
// top level of the adc spi register access sequencer
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in      | to block  | in_valid / in_ready  | mode operation reg_addr write_data
//           |           |                      | append_status rdy_level rx_byte
//   out     | from block| out_valid / out_ready| send_valid send_byte chip_select done_res
//           |           |                      | read_value rejected
//
// one event per cycle while results are taken; each transfer lands in the input register, and
// its one result is loaded into the result register as it leaves and is offered from then on.
// reset clears the phase, byte counters, job kind and both valid flags; the frame buffer
// keeps whatever it holds until a job writes it.
// a stalled result holds the result register, the input register then fills and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module adc_spi_register_access_sequencer_core #(
    parameter int REGISTER_COUNT = adc_sra_pkg::REGISTER_COUNT_DEF,
    parameter int FRAME_BYTES    = adc_sra_pkg::FRAME_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [1:0]  operation,
    input  wire logic [5:0]  reg_addr,
    input  wire logic [23:0] write_data,
    input  wire logic        append_status,
    input  wire logic        rdy_level,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             send_valid,
    output logic [7:0]       send_byte,
    output logic             chip_select,
    output logic             done_res,
    output logic [31:0]      read_value,
    output logic             rejected
);

    logic                 in_valid_reg;
    adc_sra_pkg::item_t   item_reg;
    adc_sra_pkg::ctrl_t   ctrl_reg;
    adc_sra_pkg::ctrl_t   ctrl_next;
    logic [7:0]           frame_reg  [FRAME_BYTES];
    logic [7:0]           frame_next [FRAME_BYTES];
    logic                 out_valid_reg;
    adc_sra_pkg::result_t res_reg;
    adc_sra_pkg::result_t res_next;
    logic                 advance;

    // handshake between the two register stages
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= '{mode: mode, operation: operation, reg_addr: reg_addr,
                          write_data: write_data, append_status: append_status,
                          rdy_level: rdy_level, rx_byte: rx_byte};
    end

    // step logic
    adc_sra_step #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .FRAME_BYTES    (FRAME_BYTES)
    ) u_step (
        .item       (item_reg),
        .ctrl       (ctrl_reg),
        .frame_cur  (frame_reg),
        .ctrl_next  (ctrl_next),
        .frame_next (frame_next),
        .res        (res_next)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '{phase: adc_sra_pkg::PH_IDLE, bytes_left: 4'd0,
                          bytes_received: 4'd0, cur_op: adc_sra_pkg::OP_RESET};
        else if (advance)
            ctrl_reg <= ctrl_next;
    end

    // frame buffer, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
            frame_reg <= frame_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign send_valid  = res_reg.send_valid;
    assign send_byte   = res_reg.send_byte;
    assign chip_select = res_reg.chip_select;
    assign done_res    = res_reg.done_res;
    assign read_value  = res_reg.read_value;
    assign rejected    = res_reg.rejected;

`ifndef SYNTHESIS
    // an event leaving the input register always lands a result
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after step");

    // waiting for rdy only happens on a read
    a_wait_read: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.phase == adc_sra_pkg::PH_WAIT) |-> (ctrl_reg.cur_op == adc_sra_pkg::OP_READ))
        else $error("rdy wait outside a read job");

    // a new job while not idle is flagged as rejected
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.mode == adc_sra_pkg::MODE_NEW_JOB
            && ctrl_reg.phase != adc_sra_pkg::PH_IDLE) |=> res_reg.rejected)
        else $error("busy job not rejected");

    // a byte is only shifted with the device selected
    a_send_cs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.send_valid) |-> res_reg.chip_select)
        else $error("send without chip select");

    // a finished transaction leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.done_res) |=> (ctrl_reg.phase == adc_sra_pkg::PH_IDLE))
        else $error("done without returning to idle");
`endif

endmodule

`default_nettype wire
